/* src/pjq_pkg.sv */
// shared types and codes for the print job priority queue
package pjq_pkg;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_RAISE  = 2'd1;
    localparam logic [1:0] REQ_PRINT  = 2'd2;
    localparam logic [1:0] REQ_PURGE  = 2'd3;

    localparam logic [2:0] ST_DONE      = 3'd0;
    localparam logic [2:0] ST_MERGED    = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_EMPTY     = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    localparam logic [15:0] MAX_COPIES = 16'hFFFF;
    localparam logic [3:0]  PRIO_FLOOR = 4'd1;

    // cell operations
    localparam logic [1:0] CK_HOLD      = 2'd0;
    localparam logic [1:0] CK_ADD       = 2'd1;
    localparam logic [1:0] CK_SHIFT_IN  = 2'd2;
    localparam logic [1:0] CK_SHIFT_OUT = 2'd3;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] job_code;
        logic [31:0] file_id;
        logic [7:0]  station;
        logic [3:0]  priority_req;
        logic [15:0] copies;
    } pjq_req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        head_valid;
        logic [15:0] out_job_code;
        logic [31:0] out_file_id;
        logic [7:0]  out_station;
        logic [3:0]  out_priority;
        logic [15:0] out_copies;
        logic [4:0]  occupancy;
    } pjq_resp_t;

    typedef struct packed {
        logic [15:0] code;
        logic [31:0] file;
        logic [7:0]  station;
        logic [3:0]  prio;
        logic [15:0] copies;
    } pjq_job_t;

    typedef struct packed {
        logic [1:0] kind;
        pjq_job_t   key;
        pjq_job_t   load;
    } pjq_cell_ctrl_t;

    typedef struct packed {
        logic merge_hit;
        logic code_hit;
        logic prio_le;
        logic station_hit;
    } pjq_flags_t;

endpackage

/* src/pjq_cell.sv */
// one queue slot: holds a job, compares it with the key, moves data to or from its neighbors
module pjq_cell #(
    parameter int CNT_W = 5
) (
    input  logic                    aclk,
    input  logic [CNT_W-1:0]        cell_idx,
    input  pjq_pkg::pjq_cell_ctrl_t ctrl,
    input  logic [CNT_W-1:0]        lo,
    input  logic [CNT_W-1:0]        hi,
    input  pjq_pkg::pjq_job_t       prev_job,
    input  pjq_pkg::pjq_job_t       next_job,
    output pjq_pkg::pjq_job_t       job,
    output pjq_pkg::pjq_flags_t     flags
);

    pjq_pkg::pjq_job_t job_reg;
    pjq_pkg::pjq_job_t job_next;
    logic [16:0]       sum;

    assign job = job_reg;
    assign sum = {1'b0, job_reg.copies} + {1'b0, ctrl.key.copies};

    always_comb begin
        flags.merge_hit   = (job_reg.file == ctrl.key.file) &&
                            (job_reg.station == ctrl.key.station) &&
                            (job_reg.prio != 4'd0);
        flags.code_hit    = (job_reg.code == ctrl.key.code) &&
                            (job_reg.prio > pjq_pkg::PRIO_FLOOR);
        flags.prio_le     = (job_reg.prio <= ctrl.key.prio);
        flags.station_hit = (job_reg.station == ctrl.key.station);
    end

    always_comb begin
        job_next = job_reg;
        case (ctrl.kind)
            pjq_pkg::CK_ADD: begin
                if (cell_idx == lo) begin
                    job_next.copies = sum[16] ? pjq_pkg::MAX_COPIES : sum[15:0];
                end
            end
            pjq_pkg::CK_SHIFT_IN: begin
                if (cell_idx == lo) begin
                    job_next = ctrl.load;
                end else if (cell_idx > lo && cell_idx <= hi) begin
                    job_next = prev_job;
                end
            end
            pjq_pkg::CK_SHIFT_OUT: begin
                if (cell_idx >= lo) begin
                    job_next = next_job;
                end
            end
            default: begin
                job_next = job_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        job_reg <= job_next;
    end

endmodule

/* src/print_job_priority_queue.sv */
// print job priority queue: row of job cells under a scanning controller
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | s_req  (pjq_req_t)
//  m_      | out       | m_valid / m_ready  | m_resp (pjq_resp_t)
//
// one request at a time; a scan walks the cells one slot per cycle. insert first
// looks for a job to merge with, raise for the job by code; unless that settles
// it, a second scan finds the place. print shifts out the head; purge takes out
// each station match. aresetn empties the queue; cell contents are not cleared.
// a result held by m_ready low stalls the next request only at its response step.
module print_job_priority_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  pjq_pkg::pjq_req_t   s_req,
    output logic                m_valid,
    input  logic                m_ready,
    output pjq_pkg::pjq_resp_t  m_resp
);

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN_A = 3'd1;
    localparam logic [2:0] S_SCAN_B = 3'd2;
    localparam logic [2:0] S_APPLY  = 3'd3;
    localparam logic [2:0] S_RESP   = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    scan_reg, scan_next;
    logic [CNT_W-1:0]    found_reg, found_next;
    logic [CNT_W-1:0]    lo_reg, lo_next;
    logic [CNT_W-1:0]    hi_reg, hi_next;
    logic [1:0]          kind_reg, kind_next;
    logic [3:0]          thresh_reg, thresh_next;
    logic [2:0]          status_reg, status_next;
    logic                hvalid_reg, hvalid_next;
    pjq_pkg::pjq_job_t   head_reg, head_next;
    pjq_pkg::pjq_job_t   load_reg, load_next;
    pjq_pkg::pjq_req_t   req_reg, req_next;
    logic                m_valid_reg, m_valid_next;
    pjq_pkg::pjq_resp_t  resp_reg, resp_next;

    pjq_pkg::pjq_cell_ctrl_t ctrl;
    pjq_pkg::pjq_job_t       cell_job [QUEUE_DEPTH];
    pjq_pkg::pjq_flags_t     cell_flags [QUEUE_DEPTH];
    pjq_pkg::pjq_job_t       scan_job;
    pjq_pkg::pjq_flags_t     scan_flags;
    logic [IDX_W-1:0]        scan_idx;
    logic                    scan_end;
    logic [CNT_W+4:0]        occ_wide;

    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_resp   = resp_reg;
    assign scan_idx = scan_reg[IDX_W-1:0];
    assign scan_job   = cell_job[scan_idx];
    assign scan_flags = cell_flags[scan_idx];
    assign scan_end   = (scan_reg == count_reg);
    assign occ_wide   = {5'd0, count_reg};

    always_comb begin
        ctrl.kind           = (state_reg == S_APPLY) ? kind_reg : pjq_pkg::CK_HOLD;
        ctrl.key.code       = req_reg.job_code;
        ctrl.key.file       = req_reg.file_id;
        ctrl.key.station    = req_reg.station;
        ctrl.key.prio       = thresh_reg;
        ctrl.key.copies     = req_reg.copies;
        ctrl.load           = load_reg;
    end

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            pjq_cell #(
                .CNT_W(CNT_W)
            ) u_cell (
                .aclk     (aclk),
                .cell_idx (CNT_W'(g)),
                .ctrl     (ctrl),
                .lo       (lo_reg),
                .hi       (hi_reg),
                .prev_job (cell_job[(g == 0) ? 0 : g - 1]),
                .next_job (cell_job[(g == QUEUE_DEPTH - 1) ? g : g + 1]),
                .job      (cell_job[g]),
                .flags    (cell_flags[g])
            );
        end
    endgenerate

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        scan_next    = scan_reg;
        found_next   = found_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        kind_next    = kind_reg;
        thresh_next  = thresh_reg;
        status_next  = status_reg;
        hvalid_next  = hvalid_reg;
        head_next    = head_reg;
        load_next    = load_reg;
        req_next     = req_reg;
        m_valid_next = m_valid_reg;
        resp_next    = resp_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    req_next    = s_req;
                    thresh_next = s_req.priority_req;
                    scan_next   = '0;
                    status_next = pjq_pkg::ST_DONE;
                    hvalid_next = 1'b0;
                    head_next   = '0;
                    state_next  = S_SCAN_A;
                end
            end
            S_SCAN_A: begin
                case (req_reg.req_type)
                    pjq_pkg::REQ_INSERT: begin
                        if (scan_end) begin
                            if (count_reg == DEPTH_C) begin
                                status_next = pjq_pkg::ST_FULL;
                                state_next  = S_RESP;
                            end else begin
                                scan_next  = '0;
                                state_next = S_SCAN_B;
                            end
                        end else if (scan_flags.merge_hit) begin
                            kind_next   = pjq_pkg::CK_ADD;
                            lo_next     = scan_reg;
                            status_next = pjq_pkg::ST_MERGED;
                            state_next  = S_APPLY;
                        end else begin
                            scan_next = scan_reg + 1'b1;
                        end
                    end
                    pjq_pkg::REQ_RAISE: begin
                        if (scan_end) begin
                            status_next = pjq_pkg::ST_NOT_FOUND;
                            state_next  = S_RESP;
                        end else if (scan_flags.code_hit) begin
                            found_next     = scan_reg;
                            load_next      = scan_job;
                            load_next.prio = scan_job.prio - 4'd1;
                            thresh_next    = scan_job.prio - 4'd1;
                            scan_next      = '0;
                            state_next     = S_SCAN_B;
                        end else begin
                            scan_next = scan_reg + 1'b1;
                        end
                    end
                    pjq_pkg::REQ_PRINT: begin
                        if (count_reg == '0) begin
                            status_next = pjq_pkg::ST_EMPTY;
                            state_next  = S_RESP;
                        end else begin
                            head_next   = cell_job[0];
                            hvalid_next = 1'b1;
                            kind_next   = pjq_pkg::CK_SHIFT_OUT;
                            lo_next     = '0;
                            state_next  = S_APPLY;
                        end
                    end
                    default: begin
                        // purge: remove in place, rescan the same slot afterwards
                        if (scan_end) begin
                            state_next = S_RESP;
                        end else if (scan_flags.station_hit) begin
                            kind_next  = pjq_pkg::CK_SHIFT_OUT;
                            lo_next    = scan_reg;
                            state_next = S_APPLY;
                        end else begin
                            scan_next = scan_reg + 1'b1;
                        end
                    end
                endcase
            end
            S_SCAN_B: begin
                if (req_reg.req_type == pjq_pkg::REQ_INSERT) begin
                    if (scan_end || !scan_flags.prio_le) begin
                        kind_next         = pjq_pkg::CK_SHIFT_IN;
                        lo_next           = scan_reg;
                        hi_next           = count_reg;
                        load_next.code    = req_reg.job_code;
                        load_next.file    = req_reg.file_id;
                        load_next.station = req_reg.station;
                        load_next.prio    = req_reg.priority_req;
                        load_next.copies  = req_reg.copies;
                        state_next        = S_APPLY;
                    end else begin
                        scan_next = scan_reg + 1'b1;
                    end
                end else begin
                    // raise: stop at the first slot with a larger priority number
                    if (scan_reg == found_reg || !scan_flags.prio_le) begin
                        kind_next  = pjq_pkg::CK_SHIFT_IN;
                        lo_next    = scan_reg;
                        hi_next    = found_reg;
                        state_next = S_APPLY;
                    end else begin
                        scan_next = scan_reg + 1'b1;
                    end
                end
            end
            S_APPLY: begin
                if (kind_reg == pjq_pkg::CK_SHIFT_OUT) begin
                    count_next = count_reg - 1'b1;
                end else if (kind_reg == pjq_pkg::CK_SHIFT_IN &&
                             req_reg.req_type == pjq_pkg::REQ_INSERT) begin
                    count_next = count_reg + 1'b1;
                end
                if (req_reg.req_type == pjq_pkg::REQ_PURGE) begin
                    state_next = S_SCAN_A;
                end else begin
                    state_next = S_RESP;
                end
            end
            S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next           = 1'b1;
                    resp_next.status       = status_reg;
                    resp_next.head_valid   = hvalid_reg;
                    resp_next.out_job_code = head_reg.code;
                    resp_next.out_file_id  = head_reg.file;
                    resp_next.out_station  = head_reg.station;
                    resp_next.out_priority = head_reg.prio;
                    resp_next.out_copies   = head_reg.copies;
                    resp_next.occupancy    = occ_wide[4:0];
                    state_next             = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_reg   <= scan_next;
        found_reg  <= found_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        kind_reg   <= kind_next;
        thresh_reg <= thresh_next;
        status_reg <= status_next;
        hvalid_reg <= hvalid_next;
        head_reg   <= head_next;
        load_reg   <= load_next;
        req_reg    <= req_next;
        resp_reg   <= resp_next;
    end

endmodule
